// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the SM3 lane unit.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/sm3_pkg.sv =====
// Package for the eight-lane SM3 unit: constants and round helpers.
// No dependencies.
package sm3_pkg;
    localparam int IoLanes = 8;
    localparam int DefLanes = 8;
    localparam logic [255:0] Iv = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [255:0] s;
        s = Iv << {i, 5'd0};
        return s[255:224];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    // Control from the sequencer to every lane core.
    typedef struct packed {
        logic        load_word;  // store an input word at word_pos
        logic [3:0]  word_pos;
        logic        init_cv;    // chaining value back to IV
        logic        start;      // begin compression, window from buffer or pad source
        logic        round;      // run one round
        logic [5:0]  round_idx;
        logic        finish;     // fold round registers into CV
        logic        pad_en;     // window comes from the pad builder
        logic        pad_second; // use the second pad block
        logic [3:0]  pos;        // words in buffer for the final block
        logic [2:0]  vbytes;
        logic [63:0] bits;
        logic        two_block;  // padding needs two blocks
        logic        overflow;   // message words fill the block exactly
    } ctl_t;
endpackage

// ===== hdl/sm3_hash_eight_lane_unit.sv =====
// Eight-lane SM3 unit. A non-last word is stored while idle; the 16th word
// of a block starts a compression (load, 64 rounds, fold; all lanes
// in lockstep), and no new word is taken until it is done.
// A last word costs 1 or 2 compressions, then
// 8 digest words are emitted, one per cycle when the sink is ready.
// Reset (async, active low) sets every CV to the SM3 IV and clears counters.
`include "assert_macros.svh"
module sm3_hash_eight_lane_unit #(
    parameter int LANES = sm3_pkg::DefLanes
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] word_lane0, word_lane1, word_lane2, word_lane3,
    input  logic [31:0] word_lane4, word_lane5, word_lane6, word_lane7,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  digest_index,
    output logic [31:0] digest_lane0, digest_lane1, digest_lane2, digest_lane3,
    output logic [31:0] digest_lane4, digest_lane5, digest_lane6, digest_lane7,
    output logic        digest_done
);
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_START  = 5'b00010,
        S_ROUND  = 5'b00100,
        S_FINISH = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg;
    logic [63:0] bytes_reg;
    logic [5:0]  rnd_reg;
    logic        final_reg;   // compressions belong to the padding phase
    logic        stage2_reg;  // working on the second padding block
    logic        more_reg;    // another padding block remains
    logic        ovf_reg, two_reg;
    logic [2:0]  vb_reg;
    logic [2:0]  idx_reg;
    logic        accept;
    logic [2:0]  vsat;
    logic [63:0] bytes_sum;
    logic [6:0]  tfill;       // bytes in the final block, up to 64
    logic [31:0] in_w [sm3_pkg::IoLanes];
    logic [31:0] dig_w [sm3_pkg::IoLanes];
    sm3_pkg::ctl_t ctl;

    assign in_w = '{word_lane0, word_lane1, word_lane2, word_lane3,
                    word_lane4, word_lane5, word_lane6, word_lane7};
    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign vsat = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    assign bytes_sum = bytes_reg + (last_word ? {61'd0, vsat} : 64'd4);
    assign tfill = {1'b0, pos_reg, 2'b00} + {4'd0, vsat};

    always_comb
    begin
        ctl = '0;
        ctl.load_word = accept;
        ctl.word_pos = pos_reg;
        ctl.pos = pos_reg;
        ctl.vbytes = vb_reg;
        ctl.bits = {bytes_reg[60:0], 3'd0};
        ctl.two_block = two_reg;
        ctl.overflow = ovf_reg;
        ctl.pad_en = final_reg;
        ctl.pad_second = stage2_reg;
        ctl.start = (state_reg == S_START);
        ctl.round = (state_reg == S_ROUND);
        ctl.round_idx = rnd_reg;
        ctl.finish = (state_reg == S_FINISH);
        ctl.init_cv = (state_reg == S_OUT) && out_ready && (idx_reg == 3'd7);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept && (last_word || pos_reg == 4'd15)) state_next = S_START;
            S_START:  state_next = S_ROUND;
            S_ROUND:  if (rnd_reg == 6'd63) state_next = S_FINISH;
            S_FINISH: state_next = !final_reg ? S_IDLE : (more_reg ? S_START : S_OUT);
            S_OUT:    if (out_ready && idx_reg == 3'd7) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg <= '0;
            bytes_reg <= '0;
            rnd_reg <= '0;
            final_reg <= 1'b0;
            stage2_reg <= 1'b0;
            more_reg <= 1'b0;
            ovf_reg <= 1'b0;
            two_reg <= 1'b0;
            vb_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                bytes_reg <= bytes_sum;
                vb_reg <= vsat;
                if (!last_word)
                    pos_reg <= pos_reg + 4'd1;
                else
                begin
                    final_reg <= 1'b1;
                    stage2_reg <= 1'b0;
                    ovf_reg <= (tfill == 7'd64);
                    two_reg <= (tfill >= 7'd56);
                    more_reg <= (tfill >= 7'd56);
                end
            end
            if (state_reg == S_START)
                rnd_reg <= '0;
            else if (state_reg == S_ROUND)
                rnd_reg <= rnd_reg + 6'd1;
            if (state_reg == S_FINISH && final_reg && more_reg)
            begin
                more_reg <= 1'b0;
                stage2_reg <= 1'b1;
            end
            if (state_reg == S_OUT && out_ready)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    final_reg <= 1'b0;
                    pos_reg <= '0;
                    bytes_reg <= '0;
                end
            end
        end
    end

    for (genvar l = 0; l < sm3_pkg::IoLanes; l++)
    begin : g_lane
        if (l < LANES)
        begin : g_on
            sm3_lane u_lane (
                .clk(clk), .rst_n(rst_n), .ctl(ctl), .in_word(in_w[l]),
                .dig_sel(idx_reg), .dig_word(dig_w[l])
            );
        end
        else
        begin : g_off
            assign dig_w[l] = 32'd0;
        end
    end

    // Merge: present the selected digest word of every lane.
    assign out_valid = (state_reg == S_OUT);
    assign digest_index = idx_reg;
    assign digest_done = (idx_reg == 3'd7);
    assign digest_lane0 = dig_w[0];
    assign digest_lane1 = dig_w[1];
    assign digest_lane2 = dig_w[2];
    assign digest_lane3 = dig_w[3];
    assign digest_lane4 = dig_w[4];
    assign digest_lane5 = dig_w[5];
    assign digest_lane6 = dig_w[6];
    assign digest_lane7 = dig_w[7];

    `ASSERT_IMPL(a_round_bound, clk, rst_n, state_reg == S_ROUND, rnd_reg <= 6'd63)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(idx_reg))
    `ASSERT_IMPL(a_out_final, clk, rst_n, out_valid, final_reg)
endmodule

// ===== hdl/sm3_lane.sv =====
// One SM3 lane: block buffer, message schedule window, round registers, CV.
// Depends on sm3_pkg.
module sm3_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  sm3_pkg::ctl_t   ctl,
    input  logic [31:0]     in_word,
    input  logic [2:0]      dig_sel,
    output logic [31:0]     dig_word
);
    logic [31:0] buf_reg [16];
    logic [31:0] last_reg;
    logic [31:0] w_reg [16];
    logic [31:0] r_reg [8];
    logic [31:0] cv_reg [8];
    logic [31:0] pad_w [16];
    logic [31:0] w_new;
    logic [31:0] t_rot, a12, ss1, ss2, ff, gg, tt1, tt2;

    // Padded block word i, built from buffer, last word and length.
    always_comb
    begin
        logic [5:0] t;
        logic [31:0] mask;
        t = {ctl.pos, 2'b00} + {3'd0, ctl.vbytes};
        mask = (ctl.vbytes >= 3'd4) ? 32'hffffffff : ~(32'hffffffff >> {ctl.vbytes, 3'd0});
        for (int i = 0; i < 16; i++)
        begin
            pad_w[i] = 32'd0;
            if (!ctl.pad_second)
            begin
                if (4'(i) < ctl.pos)
                    pad_w[i] = buf_reg[i];
                else if (4'(i) == ctl.pos)
                    pad_w[i] = last_reg & mask;
                // a full final block carries no marker; it goes in the next block
                if (!ctl.overflow && 4'(i) == t[5:2])
                    pad_w[i] = pad_w[i] | (32'h80 << (5'd24 - {t[1:0], 3'd0}));
            end
            else if (ctl.overflow && i == 0)
                pad_w[i] = 32'h80000000;
            if (i == 14 && (ctl.two_block == ctl.pad_second))
                pad_w[i] = ctl.bits[63:32];
            if (i == 15 && (ctl.two_block == ctl.pad_second))
                pad_w[i] = ctl.bits[31:0];
        end
    end

    assign w_new = sm3_pkg::p1(w_reg[0] ^ w_reg[7] ^ sm3_pkg::rotl(w_reg[13], 5'd15))
                   ^ sm3_pkg::rotl(w_reg[3], 5'd7) ^ w_reg[10];

    always_comb
    begin
        t_rot = sm3_pkg::rotl((ctl.round_idx < 6'd16) ? 32'h79cc4519 : 32'h7a879d8a,
                              ctl.round_idx[4:0]);
        a12 = sm3_pkg::rotl(r_reg[0], 5'd12);
        ss1 = sm3_pkg::rotl(a12 + r_reg[4] + t_rot, 5'd7);
        ss2 = ss1 ^ a12;
        if (ctl.round_idx < 6'd16)
        begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        else
        begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + r_reg[7] + ss1 + w_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_word)
        begin
            buf_reg[ctl.word_pos] <= in_word;
            last_reg <= in_word;
        end
        if (ctl.start)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= ctl.pad_en ? pad_w[i] : buf_reg[i];
            for (int i = 0; i < 8; i++)
                r_reg[i] <= cv_reg[i];
        end
        else if (ctl.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= sm3_pkg::rotl(r_reg[1], 5'd9);
            r_reg[1] <= r_reg[0];
            r_reg[0] <= tt1;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= sm3_pkg::rotl(r_reg[5], 5'd19);
            r_reg[5] <= r_reg[4];
            r_reg[4] <= sm3_pkg::p0(tt2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= sm3_pkg::iv_word(3'(i));
        end
        else if (ctl.init_cv)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= sm3_pkg::iv_word(3'(i));
        end
        else if (ctl.finish)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= cv_reg[i] ^ r_reg[i];
        end
    end

    assign dig_word = cv_reg[dig_sel];
endmodule
